>>> rtl/core/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants for the fuzzy subsequence scorer
// Character classes, score bounds, register indexes and the per-text state.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int unsigned QUERY_BYTES = 32;
  localparam int unsigned QUERY_WORDS = 4;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned SCORE_W     = 14;
  localparam int unsigned OUT_SCORE_W = 13;
  localparam int unsigned BONUS_W     = 5;

  localparam logic [COUNT_W-1:0] QLEN_MAX = COUNT_W'(QUERY_BYTES);

  localparam logic signed [SCORE_W-1:0] SCORE_LOW  = -14'sd4096;
  localparam logic signed [SCORE_W:0]   SCORE_HIGH = 15'sd8191;

  localparam logic [BONUS_W-1:0] BONUS_BOUNDARY = 5'd16;
  localparam logic [BONUS_W-1:0] BONUS_CAMEL    = 5'd8;
  localparam logic [BONUS_W-1:0] BONUS_RUN      = 5'd4;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_LENGTH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_W0     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_W1     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_W2     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_W3     = 3'd4;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [SCORE_W-1:0] score;
    logic [7:0]                prev_char;
    logic                      first;
    logic                      prev_match;
  } text_state_t;

  localparam text_state_t TEXT_STATE_INIT = '{
    count:      '0,
    score:      '0,
    prev_char:  '0,
    first:      1'b1,
    prev_match: 1'b0
  };

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return is_upper(c) ? c + CASE_OFS : c;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_UNDER) || (c == CH_DASH) ||
           (c == CH_DOT) || (c == CH_SPACE);
  endfunction

endpackage

>>> rtl/core/fss_step.sv
// ----------------------------------------------------------------------------
// fss_step: one text byte against the current query byte
// Compares with case folding, picks the bonus or gap penalty and forms the
// next text state and the end-of-text verdict.
// ----------------------------------------------------------------------------
module fss_step (
  input  fss_pkg::text_state_t                     state,
  input  logic [7:0]                               text_char,
  input  logic [7:0]                               query_char,
  input  logic [fss_pkg::COUNT_W-1:0]              qlen,
  output fss_pkg::text_state_t                     state_next,
  output logic                                     matched,
  output logic signed [fss_pkg::OUT_SCORE_W-1:0]   match_score
);

  logic                              active;
  logic                              hit;
  logic [fss_pkg::BONUS_W-1:0]       bonus;
  logic signed [fss_pkg::SCORE_W:0]  sum;
  logic signed [fss_pkg::SCORE_W-1:0] score_upd;

  assign active = state.count < qlen;
  assign hit    = fss_pkg::fold_case(text_char) == fss_pkg::fold_case(query_char);

  always_comb begin
    bonus = '0;
    if (state.first || fss_pkg::is_separator(state.prev_char)) begin
      bonus = fss_pkg::BONUS_BOUNDARY;
    end else if (fss_pkg::is_lower(state.prev_char) && fss_pkg::is_upper(text_char)) begin
      bonus = fss_pkg::BONUS_CAMEL;
    end
    if (state.prev_match) begin
      bonus = bonus + fss_pkg::BONUS_RUN;
    end
  end

  assign sum = $signed({state.score[fss_pkg::SCORE_W-1], state.score}) +
               $signed({{(fss_pkg::SCORE_W + 1 - fss_pkg::BONUS_W){1'b0}}, bonus});

  always_comb begin
    score_upd = state.score;
    if (hit) begin
      score_upd = (sum > fss_pkg::SCORE_HIGH) ? fss_pkg::SCORE_HIGH[fss_pkg::SCORE_W-1:0]
                                              : sum[fss_pkg::SCORE_W-1:0];
    end else if (state.score > fss_pkg::SCORE_LOW) begin
      score_upd = state.score - 14'sd1;
    end
  end

  always_comb begin
    state_next = state;
    if (active) begin
      state_next.score      = score_upd;
      state_next.prev_match = hit;
      if (hit) begin
        state_next.count = state.count + 6'd1;
      end
    end
    state_next.prev_char = text_char;
    state_next.first     = 1'b0;
  end

  assign matched     = (qlen == '0) || (state_next.count >= qlen);
  assign match_score = (matched && (qlen != '0)) ? state_next.score[fss_pkg::OUT_SCORE_W-1:0]
                                                 : '0;

endmodule

>>> rtl/core/fuzzy_subsequence_scorer.sv
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer: streaming case-insensitive subsequence scorer
// A last byte waits in the input stage; its result is registered onto m_tvalid.
// Throughput: one byte per cycle; a last byte waits only while a result is held.
// One result per text, on the byte marked by s_tlast; state then restarts.
// Reset (rst, synchronous) empties both stages, clears the query and state.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] text_char
  input  logic                             s_tlast,   // last_char
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // [0] matched, [13:1] match_score
  input  logic                             cfg_wr_en,
  input  logic [fss_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [fss_pkg::COUNT_W-1:0]    query_length;
  logic [fss_pkg::CFG_DATA_W-1:0] query_words [fss_pkg::QUERY_WORDS];

  logic                 in_valid;
  logic [7:0]           in_char;
  logic                 in_last;
  logic                 out_free;
  logic                 advance;

  fss_pkg::text_state_t state;
  fss_pkg::text_state_t state_next;

  logic [fss_pkg::COUNT_W-1:0]             qlen;
  logic [4:0]                              qidx;
  logic [7:0]                              query_char;
  logic                                    step_matched;
  logic signed [fss_pkg::OUT_SCORE_W-1:0]  step_score;

  logic                                    out_matched;
  logic signed [fss_pkg::OUT_SCORE_W-1:0]  out_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      for (int i = 0; i < fss_pkg::QUERY_WORDS; i++) begin
        query_words[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        fss_pkg::CFG_QUERY_LENGTH: query_length   <= cfg_wdata[fss_pkg::COUNT_W-1:0];
        fss_pkg::CFG_QUERY_W0:     query_words[0] <= cfg_wdata;
        fss_pkg::CFG_QUERY_W1:     query_words[1] <= cfg_wdata;
        fss_pkg::CFG_QUERY_W2:     query_words[2] <= cfg_wdata;
        fss_pkg::CFG_QUERY_W3:     query_words[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign qlen = (query_length > fss_pkg::QLEN_MAX) ? fss_pkg::QLEN_MAX : query_length;

  // only read while count < qlen, so the low five bits address the byte
  assign qidx       = state.count[4:0];
  assign query_char = query_words[qidx[4:3]][{qidx[2:0], 3'b000} +: 8];

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  fss_step u_step (
    .state       (state),
    .text_char   (in_char),
    .query_char  (query_char),
    .qlen        (qlen),
    .state_next  (state_next),
    .matched     (step_matched),
    .match_score (step_score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fss_pkg::TEXT_STATE_INIT;
    end else if (advance) begin
      state <= in_last ? fss_pkg::TEXT_STATE_INIT : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_matched <= step_matched;
      out_score   <= step_score;
    end
  end

  assign m_tdata = {2'b00, out_score, out_matched};

endmodule
